[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL; bodies drop out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// check prop at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check that cond never holds outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

[rtl/core/ttsm_pkg.sv]
// ----------------------------------------------------------------------------
// ttsm_pkg
// Shared constants of the thermal throttle state machine.
// ----------------------------------------------------------------------------
package ttsm_pkg;

   // default width of a temperature value inside the block
   localparam int TEMP_BITS_DEFAULT = 8;

   // configuration register indexes
   localparam logic [2:0] CSR_THROTTLE_ENABLE = 3'd0;
   localparam logic [2:0] CSR_HOTPLUG_PRESENT = 3'd1;
   localparam logic [2:0] CSR_HOTPLUG_TEMP    = 3'd2;
   localparam logic [2:0] CSR_COLD_THR        = 3'd3;
   localparam logic [2:0] CSR_LEVEL1_THR      = 3'd4;
   localparam logic [2:0] CSR_LEVEL2_THR      = 3'd5;
   localparam logic [2:0] CSR_LEVEL3_THR      = 3'd6;

   // manager state codes
   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_COLD   = 3'd1;
   localparam logic [2:0] ST_NORMAL = 3'd2;
   localparam logic [2:0] ST_L1     = 3'd3;
   localparam logic [2:0] ST_L2     = 3'd4;
   localparam logic [2:0] ST_L3     = 3'd5;

   // throttle level codes
   localparam logic [1:0] LVL_NONE = 2'd0;
   localparam logic [1:0] LVL_3    = 2'd3;

   // handled flag bits
   localparam int FL_COLD_BIT    = 0;
   localparam int FL_HOTPLUG_BIT = 4;

endpackage

[rtl/core/thermal_throttle_state_machine.sv]
// ----------------------------------------------------------------------------
// thermal_throttle_state_machine: per-tick thermal manager with hysteresis.
// Result beat: registered in the result register; it appears in the cycle after the sample is accepted.
// Throughput: one sample per cycle while the result is not stalled; state updates in the accepting cycle.
// Reset: synchronous; state init, flags clear, registers at their defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module thermal_throttle_state_machine
   import ttsm_pkg::*;
#(
   parameter int TEMP_BITS = TEMP_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // configuration write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   // sample channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_temperature,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_thermal_state,
   output logic        rsp_avs_off,
   output logic        rsp_avs_on,
   output logic        rsp_limit_free,
   output logic [1:0]  rsp_limit_level,
   output logic        rsp_hotplug_up,
   output logic        rsp_hotplug_down,
   output logic [1:0]  rsp_log_level
);

   // configuration registers
   logic        enable_ff;
   logic        hp_present_ff;
   logic [7:0]  hp_temp_ff;
   logic [15:0] cold_thr_ff;
   logic [15:0] l1_thr_ff;
   logic [15:0] l2_thr_ff;
   logic [15:0] l3_thr_ff;

   // manager state
   logic [2:0] cur_ff, cur_in;
   logic [2:0] prev_ff, prev_in;
   logic [4:0] flags_ff, flags_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] state_ff;
   logic       avs_off_ff, avs_off_in;
   logic       avs_on_ff, avs_on_in;
   logic       free_ff, free_in;
   logic [1:0] limit_ff, limit_in;
   logic       hp_up_ff, hp_up_in;
   logic       hp_down_ff, hp_down_in;
   logic [1:0] log_ff, log_in;

   logic accept;

   // sample and threshold fields
   logic [TEMP_BITS-1:0] t;
   logic [TEMP_BITS-1:0] cold_start, cold_stop;
   logic [TEMP_BITS-1:0] l1_start;
   logic [TEMP_BITS-1:0] lvl_start, lvl_stop, next_start;
   logic                 has_next;
   logic [1:0]           lv;
   logic [4:0]           lv_bit;
   logic                 hot_enough;

   // extract the stop field; bits above the register read as zero
   function automatic logic [TEMP_BITS-1:0] stop_of(input logic [15:0] r);
      logic [31:0] ext;
      ext = 32'(r);
      return TEMP_BITS'(ext >> TEMP_BITS);
   endfunction

   assign t          = TEMP_BITS'(req_temperature);
   assign cold_start = cold_thr_ff[TEMP_BITS-1:0];
   assign cold_stop  = stop_of(cold_thr_ff);
   assign l1_start   = l1_thr_ff[TEMP_BITS-1:0];
   assign lv         = 2'(cur_ff - ST_NORMAL);
   assign lv_bit     = 5'(1) << lv;
   assign hot_enough = 16'(t) >= 16'(hp_temp_ff);

   // pick the thresholds of the current level and the one above
   always_comb begin
      lvl_start  = l1_thr_ff[TEMP_BITS-1:0];
      lvl_stop   = stop_of(l1_thr_ff);
      next_start = l2_thr_ff[TEMP_BITS-1:0];
      has_next   = 1'b1;
      unique case (cur_ff)
         ST_L2: begin
            lvl_start  = l2_thr_ff[TEMP_BITS-1:0];
            lvl_stop   = stop_of(l2_thr_ff);
            next_start = l3_thr_ff[TEMP_BITS-1:0];
         end
         ST_L3: begin
            lvl_start  = l3_thr_ff[TEMP_BITS-1:0];
            lvl_stop   = stop_of(l3_thr_ff);
            has_next   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // step the manager for one sample
   always_comb begin
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      flags_in   = flags_ff;
      avs_off_in = 1'b0;
      avs_on_in  = 1'b0;
      free_in    = 1'b0;
      limit_in   = LVL_NONE;
      hp_up_in   = 1'b0;
      hp_down_in = 1'b0;
      log_in     = LVL_NONE;
      unique case (cur_ff)
         ST_INIT: begin
            cur_in  = ST_COLD;
            prev_in = ST_COLD;
         end
         ST_COLD: begin
            if (t <= cold_start && !flags_ff[FL_COLD_BIT]) begin
               if (|flags_ff[3:1]) begin
                  hp_up_in = flags_ff[FL_HOTPLUG_BIT] && hp_present_ff;
                  free_in  = 1'b1;
                  flags_in = '0;
               end
               avs_off_in               = 1'b1;
               flags_in[FL_COLD_BIT]    = 1'b1;
               prev_in                  = cur_ff;
            end else if (t >= cold_stop) begin
               avs_on_in = 1'b1;
               cur_in    = ST_NORMAL;
            end
         end
         ST_NORMAL: begin
            if (t <= cold_start) begin
               cur_in = ST_COLD;
            end else if (t >= l1_start) begin
               cur_in = ST_L1;
            end else if (|flags_ff) begin
               if (|flags_ff[3:1]) begin
                  hp_up_in = flags_ff[FL_HOTPLUG_BIT] && hp_present_ff;
                  free_in  = 1'b1;
               end
               flags_in = '0;
               prev_in  = cur_ff;
            end
         end
         ST_L1, ST_L2, ST_L3: begin
            if (t <= lvl_stop) begin
               cur_in = cur_ff - 3'd1;
            end else if (has_next && t >= next_start) begin
               cur_in = cur_ff + 3'd1;
            end else if (t >= lvl_start && (flags_ff & lv_bit) == '0) begin
               hp_up_in = flags_ff[FL_HOTPLUG_BIT] && hp_present_ff;
               if ((flags_ff & ~lv_bit) != '0) begin
                  flags_in = '0;
               end
               if (enable_ff) begin
                  limit_in = lv;
               end
               if (prev_ff < cur_ff) begin
                  log_in = lv;
               end
               flags_in = flags_in | lv_bit;
               prev_in  = cur_ff;
            end else if (cur_ff == ST_L3 && enable_ff && hot_enough &&
                         !flags_ff[FL_HOTPLUG_BIT] && hp_present_ff) begin
               hp_down_in               = 1'b1;
               flags_in[FL_HOTPLUG_BIT] = 1'b1;
            end
         end
         default: begin
            cur_in = ST_INIT;
         end
      endcase
   end

   // take a sample whenever the result register is free or draining
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b1;
         hp_present_ff <= 1'b1;
         hp_temp_ff    <= 8'hFF;
         cold_thr_ff   <= 16'h0000;
         l1_thr_ff     <= 16'hFFFF;
         l2_thr_ff     <= 16'hFFFF;
         l3_thr_ff     <= 16'hFFFF;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THROTTLE_ENABLE: enable_ff     <= csr_wdata[0];
            CSR_HOTPLUG_PRESENT: hp_present_ff <= csr_wdata[0];
            CSR_HOTPLUG_TEMP:    hp_temp_ff    <= csr_wdata[7:0];
            CSR_COLD_THR:        cold_thr_ff   <= csr_wdata;
            CSR_LEVEL1_THR:      l1_thr_ff     <= csr_wdata;
            CSR_LEVEL2_THR:      l2_thr_ff     <= csr_wdata;
            CSR_LEVEL3_THR:      l3_thr_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // advance manager state on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= ST_INIT;
         prev_ff      <= ST_INIT;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            cur_ff   <= cur_in;
            prev_ff  <= prev_in;
            flags_ff <= flags_in;
         end
      end
   end

   // load the result beat
   always_ff @(posedge clock) begin
      if (accept) begin
         state_ff   <= cur_in;
         avs_off_ff <= avs_off_in;
         avs_on_ff  <= avs_on_in;
         free_ff    <= free_in;
         limit_ff   <= limit_in;
         hp_up_ff   <= hp_up_in;
         hp_down_ff <= hp_down_in;
         log_ff     <= log_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_thermal_state = state_ff;
   assign rsp_avs_off       = avs_off_ff;
   assign rsp_avs_on        = avs_on_ff;
   assign rsp_limit_free    = free_ff;
   assign rsp_limit_level   = limit_ff;
   assign rsp_hotplug_up    = hp_up_ff;
   assign rsp_hotplug_down  = hp_down_ff;
   assign rsp_log_level     = log_ff;

   // checks on the manager and the result register
   `ASSERT_CLK(a_state_range, clock, reset, cur_ff <= ST_L3, "state register left the code range")
   `ASSERT_CLK(a_stall_blocks, clock, reset, (rsp_valid_ff && !rsp_ready) |-> !req_ready, "sample taken while result stalled")
   `ASSERT_CLK(a_down_in_l3, clock, reset, (rsp_valid && rsp_hotplug_down) |-> (rsp_thermal_state == ST_L3 && rsp_limit_level == LVL_NONE), "hotplug down outside level three")
   `ASSERT_NEVER(a_avs_both, clock, reset, rsp_valid && rsp_avs_off && rsp_avs_on, "voltage scaling off and on in one beat")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the thermal throttle state machine
// Streams temperature samples through the valid/ready sample channel under a
// sequence of threshold settings and compares every result beat, field by
// field, against an in-bench model of the manager's state, previous state and
// handled flags. Both channels idle in random bursts, except in the phases that turn idling off.
// ----------------------------------------------------------------------------
module tb_top;
   import ttsm_pkg::*;

   localparam int CLOCK_HALF_NS    = 10;
   localparam int RESET_CYCLES     = 5;
   localparam int RANDOM_PHASES    = 9;
   localparam int WALK_ITEMS       = 190;
   localparam int EXTREME_ITEMS    = 60;
   localparam int RAW_ITEMS        = 80;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int DRAIN_TAIL       = 4;
   localparam int WATCHDOG_LIMIT   = 1000;

   // one result beat of the manager
   typedef struct {
      logic [2:0] thermal_state;
      logic       avs_off;
      logic       avs_on;
      logic       limit_free;
      logic [1:0] limit_level;
      logic       hotplug_up;
      logic       hotplug_down;
      logic [1:0] log_level;
   } throttle_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_THROTTLE_ENABLE;
   logic [15:0] csr_wdata = 16'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_temperature = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_thermal_state;
   logic        rsp_avs_off;
   logic        rsp_avs_on;
   logic        rsp_limit_free;
   logic [1:0]  rsp_limit_level;
   logic        rsp_hotplug_up;
   logic        rsp_hotplug_down;
   logic [1:0]  rsp_log_level;

   // samples waiting for the driver, results waiting for the monitor
   logic [7:0]         pending_temps[$];
   throttle_event_type expected_events[$];

   // manager copy: configuration as last written, then state and flags
   logic        cfg_enable = 1'b1;
   logic        cfg_hp_present = 1'b1;
   logic [7:0]  cfg_hp_temp = 8'hFF;
   logic [15:0] cfg_cold = 16'h0000;
   logic [15:0] cfg_level [0:3] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF};
   logic [2:0]  mgr_state = ST_INIT;
   logic [2:0]  mgr_prev = ST_INIT;
   logic [4:0]  mgr_flags = 5'd0;

   bit          idle_enable = 1'b1;
   int unsigned hold_requests = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned send_gap = 0;

   thermal_throttle_state_machine dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_temperature   (req_temperature),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_thermal_state (rsp_thermal_state),
      .rsp_avs_off       (rsp_avs_off),
      .rsp_avs_on        (rsp_avs_on),
      .rsp_limit_free    (rsp_limit_free),
      .rsp_limit_level   (rsp_limit_level),
      .rsp_hotplug_up    (rsp_hotplug_up),
      .rsp_hotplug_down  (rsp_hotplug_down),
      .rsp_log_level     (rsp_log_level)
   );

   initial begin
      forever #(CLOCK_HALF_NS) clock = ~clock;
   end

   // Advance the manager by one polling tick and return the beat it reports.
   function automatic throttle_event_type step_manager(input logic [7:0] temp);
      throttle_event_type ev;
      logic [1:0]      lv;
      logic [4:0]      lv_bit;
      logic [7:0]      cold_enter;
      logic [7:0]      cold_leave;
      ev = '{default: '0};
      ev.limit_level = LVL_NONE;
      ev.log_level = LVL_NONE;
      cold_enter = cfg_cold[7:0];
      cold_leave = cfg_cold[15:8];
      case (mgr_state)
         ST_INIT: begin
            mgr_state = ST_COLD;
            mgr_prev = ST_COLD;
         end
         ST_COLD: begin
            if (temp <= cold_enter && !mgr_flags[FL_COLD_BIT]) begin
               // release any level still held before marking cold
               if (mgr_flags[3:1] != 3'd0) begin
                  ev.limit_free = 1'b1;
                  ev.hotplug_up = mgr_flags[FL_HOTPLUG_BIT] && cfg_hp_present;
                  mgr_flags = 5'd0;
               end
               ev.avs_off = 1'b1;
               mgr_flags[FL_COLD_BIT] = 1'b1;
               mgr_prev = mgr_state;
            end else if (temp >= cold_leave) begin
               ev.avs_on = 1'b1;
               mgr_state = ST_NORMAL;
            end
         end
         ST_NORMAL: begin
            if (temp <= cold_enter) begin
               mgr_state = ST_COLD;
            end else if (temp >= cfg_level[1][7:0]) begin
               mgr_state = ST_L1;
            end else if (mgr_flags != 5'd0) begin
               // settle back to normal: drop every handled mark
               if (mgr_flags[3:1] != 3'd0) begin
                  ev.limit_free = 1'b1;
                  ev.hotplug_up = mgr_flags[FL_HOTPLUG_BIT] && cfg_hp_present;
               end
               mgr_flags = 5'd0;
               mgr_prev = mgr_state;
            end
         end
         ST_L1, ST_L2, ST_L3: begin
            lv = 2'(mgr_state - ST_NORMAL);
            lv_bit = 5'b00001 << lv;
            if (temp <= cfg_level[lv][15:8]) begin
               mgr_state = mgr_state - 3'd1;
            end else if (lv != LVL_3 && temp >= cfg_level[lv + 2'd1][7:0]) begin
               mgr_state = mgr_state + 3'd1;
            end else if (temp >= cfg_level[lv][7:0] && !mgr_flags[lv]) begin
               // handle this level: cpus come back, limit and log apply
               if (mgr_flags[FL_HOTPLUG_BIT] && cfg_hp_present)
                  ev.hotplug_up = 1'b1;
               if ((mgr_flags & ~lv_bit) != 5'd0)
                  mgr_flags = 5'd0;
               if (cfg_enable)
                  ev.limit_level = lv;
               if (mgr_prev < mgr_state)
                  ev.log_level = lv;
               mgr_flags = mgr_flags | lv_bit;
               mgr_prev = mgr_state;
            end else if (mgr_state == ST_L3 && cfg_enable && temp >= cfg_hp_temp &&
                         !mgr_flags[FL_HOTPLUG_BIT] && cfg_hp_present) begin
               ev.hotplug_down = 1'b1;
               mgr_flags[FL_HOTPLUG_BIT] = 1'b1;
            end
         end
         default: begin
            mgr_state = ST_INIT;
         end
      endcase
      ev.thermal_state = mgr_state;
      return ev;
   endfunction

   task automatic check_field(input string field, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, got %0d", field, want_v, got_v);
         mismatch_count++;
      end
   endtask

   // Drive one register write for a single cycle.
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Write all registers while the block is idle and mirror them.
   task automatic apply_config(input logic en, input logic present, input logic [7:0] hp,
                               input logic [15:0] cold, input logic [15:0] l1,
                               input logic [15:0] l2, input logic [15:0] l3);
      write_reg(CSR_THROTTLE_ENABLE, {15'd0, en});
      write_reg(CSR_HOTPLUG_PRESENT, {15'd0, present});
      write_reg(CSR_HOTPLUG_TEMP, {8'd0, hp});
      write_reg(CSR_COLD_THR, cold);
      write_reg(CSR_LEVEL1_THR, l1);
      write_reg(CSR_LEVEL2_THR, l2);
      write_reg(CSR_LEVEL3_THR, l3);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_enable = en;
      cfg_hp_present = present;
      cfg_hp_temp = hp;
      cfg_cold = cold;
      cfg_level[1] = l1;
      cfg_level[2] = l2;
      cfg_level[3] = l3;
   endtask

   // Hold the sender until every sample is out and every result is back.
   task automatic drain();
      while (pending_temps.size() != 0 || req_valid || expected_events.size() != 0)
         @(negedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   // Sample driver: predict on each accepted beat, then load the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            expected_events.push_back(step_manager(req_temperature));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_temps.size() > 0) begin
               req_valid <= 1'b1;
               req_temperature <= pending_temps.pop_front();
               if (idle_enable && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each beat, then decide the next ready level.
   always @(posedge clock) begin : result_monitor
      throttle_event_type want;
      int unsigned     ready_hold;
      int unsigned     holds_served;
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold = 0;
         holds_served = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               $error("result beat with no sample pending: thermal_state %0d",
                      rsp_thermal_state);
               mismatch_count++;
            end else begin
               want = expected_events.pop_front();
               check_field("thermal_state", 8'(want.thermal_state), 8'(rsp_thermal_state));
               check_field("avs_off", 8'(want.avs_off), 8'(rsp_avs_off));
               check_field("avs_on", 8'(want.avs_on), 8'(rsp_avs_on));
               check_field("limit_free", 8'(want.limit_free), 8'(rsp_limit_free));
               check_field("limit_level", 8'(want.limit_level), 8'(rsp_limit_level));
               check_field("hotplug_up", 8'(want.hotplug_up), 8'(rsp_hotplug_up));
               check_field("hotplug_down", 8'(want.hotplug_down), 8'(rsp_hotplug_down));
               check_field("log_level", 8'(want.log_level), 8'(rsp_log_level));
            end
         end
         // back-pressure: a long hold on request, else short random bursts
         if (holds_served != hold_requests) begin
            holds_served++;
            ready_hold = LONG_HOLD_CYCLES;
         end
         if (ready_hold > 0) begin
            ready_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_enable && $urandom_range(0, 7) == 0)
               ready_hold = $urandom_range(1, 10);
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int         item_count;
      int         temp_now;
      int         target;
      int         step;
      logic       en;
      logic       present;
      logic [7:0] c_enter, c_leave, hp;
      logic [7:0] l1_stop, l1_start, l2_stop, l2_start, l3_stop, l3_start;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: init tick, cold entry, leave cold, level one and back
      @(negedge clock);
      pending_temps = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd128, 8'd0};
      drain();

      // climb the full ladder and come back down through every hysteresis band
      apply_config(1'b1, 1'b1, 8'd110, 16'h140A, 16'h323C, 16'h4650, 16'h5A64);
      @(negedge clock);
      pending_temps = '{8'd5, 8'd5, 8'd25, 8'd65, 8'd65, 8'd85, 8'd85, 8'd105, 8'd105,
                        8'd120, 8'd95, 8'd85, 8'd85, 8'd45, 8'd45, 8'd45, 8'd5, 8'd5};
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // stack thresholds bottom to top so the walk can reach every level
         c_enter = 8'($urandom_range(0, 40));
         c_leave = c_enter + 8'($urandom_range(1, 20));
         l1_stop = c_leave + 8'($urandom_range(5, 30));
         l1_start = l1_stop + 8'($urandom_range(1, 15));
         l2_stop = l1_start + 8'($urandom_range(1, 20));
         l2_start = l2_stop + 8'($urandom_range(1, 15));
         l3_stop = l2_start + 8'($urandom_range(1, 20));
         l3_start = l3_stop + 8'($urandom_range(1, 15));
         hp = l3_start + 8'($urandom_range(0, 30));
         en = ($urandom_range(0, 3) != 0);
         present = ($urandom_range(0, 3) != 0);
         item_count = WALK_ITEMS;
         case (phase)
            0: begin
               apply_config(1'b0, 1'b1, hp, {c_leave, c_enter}, {l1_stop, l1_start},
                            {l2_stop, l2_start}, {l3_stop, l3_start});
            end
            1: begin
               apply_config(1'b1, 1'b0, hp, {c_leave, c_enter}, {l1_stop, l1_start},
                            {l2_stop, l2_start}, {l3_stop, l3_start});
            end
            2: begin
               apply_config(1'b1, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
               item_count = EXTREME_ITEMS;
            end
            3: begin
               apply_config(1'b0, 1'b0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
               item_count = EXTREME_ITEMS;
            end
            4: begin
               // unordered thresholds
               apply_config(en, present, 8'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom));
               item_count = RAW_ITEMS;
            end
            default: begin
               apply_config(en, present, hp, {c_leave, c_enter}, {l1_stop, l1_start},
                            {l2_stop, l2_start}, {l3_stop, l3_start});
            end
         endcase

         @(negedge clock);
         // steady sender with a long receiver hold here, no idling at the end
         idle_enable = (phase != 5 && phase != RANDOM_PHASES - 1);
         if (phase == 5)
            hold_requests++;

         // drift toward random targets so levels are entered and left slowly
         temp_now = $urandom_range(0, 255);
         target = $urandom_range(0, 255);
         repeat (item_count) begin
            if (temp_now == target)
               target = $urandom_range(0, 255);
            step = $urandom_range(1, 8);
            if (temp_now < target)
               temp_now = (target - temp_now < step) ? target : temp_now + step;
            else
               temp_now = (temp_now - target < step) ? target : temp_now - step;
            case ($urandom_range(0, 31))
               0:       pending_temps.push_back(8'd0);
               1:       pending_temps.push_back(8'd255);
               2, 3:    pending_temps.push_back(8'($urandom_range(0, 255)));
               default: pending_temps.push_back(8'(temp_now));
            endcase
         end
         drain();
      end

      if (mismatch_count == 0 && expected_events.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ttsm_pkg.sv
rtl/core/thermal_throttle_state_machine.sv
tb/sv/tb_top.sv
